@@ hw/rtl/rsi_pkg.sv @@
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared widths, register indexes, data types and helpers for the ray and
// sphere intersection core.
// ----------------------------------------------------------------------------
package rsi_pkg;

  localparam int PosW  = 24;            // Q12.12 coordinate
  localparam int DirW  = 16;            // Q1.14 direction component
  localparam int RadW  = 23;            // unsigned Q11.12 radius
  localparam int InW   = 3 * PosW + 3 * DirW;
  localparam int VecW  = PosW + 1;      // origin minus center, exact
  localparam int PdW   = VecW + DirW;   // one term of the dot product
  localparam int PvW   = 2 * VecW;      // one term of the squared length
  localparam int RrW   = 2 * RadW;      // radius squared
  localparam int DotW  = PdW + 2;       // sum of three terms
  localparam int LenW  = PvW + 2;
  localparam int LrW   = LenW + 1;      // squared length minus radius squared
  localparam int BW    = DotW + 1 - 14; // b in Q.12
  localparam int BbW   = 2 * BW;
  localparam int DiscW = BbW + 1;
  localparam int SqW   = 56;            // radicand and square root work width
  localparam int RootW = 28;            // root width of a 56-bit radicand
  localparam int NumCells = RootW;      // one root bit per cell
  localparam int TW    = 32;            // result distance width
  localparam int OutW  = 2 * TW;
  localparam int IdxW  = 8;

  localparam logic [IdxW-1:0] RegCenterX = IdxW'(0);
  localparam logic [IdxW-1:0] RegCenterY = IdxW'(1);
  localparam logic [IdxW-1:0] RegCenterZ = IdxW'(2);
  localparam logic [IdxW-1:0] RegRadius  = IdxW'(3);

  localparam logic [RadW-1:0] RadiusReset = RadW'(4096);

  // Work item handed from cell to cell along the square root chain.
  typedef struct packed {
    logic                 hit;
    logic signed [BW-1:0] b;
    logic [SqW-1:0]       x;    // remaining radicand
    logic [SqW-1:0]       res;  // partial root
  } sq_data_t;

  // Clamp a 33-bit signed sum to the signed 32-bit range.
  function automatic logic [TW-1:0] sat32(input logic signed [TW:0] v);
    logic [TW-1:0] r;
    if (v[TW] != v[TW-1]) begin
      r = v[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      r = v[TW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/rsi_front.sv @@
// ----------------------------------------------------------------------------
// rsi_front
// Six-stage arithmetic front end: offset from the center, dot products,
// b, b squared and the discriminant that feeds the square root chain.
// ----------------------------------------------------------------------------
module rsi_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rsi_pkg::InW-1:0]             s_tdata,
  input  logic signed [rsi_pkg::PosW-1:0]     center_x,
  input  logic signed [rsi_pkg::PosW-1:0]     center_y,
  input  logic signed [rsi_pkg::PosW-1:0]     center_z,
  input  logic [rsi_pkg::RadW-1:0]            radius,
  output logic                                out_valid,
  output rsi_pkg::sq_data_t                   out_data,
  input  logic                                out_ready
);
  import rsi_pkg::*;

  logic signed [PosW-1:0] cen [3];
  logic signed [PosW-1:0] org [3];
  logic signed [DirW-1:0] dir [3];

  logic v1, v2, v3, v4, v5;
  logic take1, take2, take3, take4, take5, take6;

  logic signed [VecW-1:0] vec1 [3];
  logic signed [DirW-1:0] dir1 [3];
  logic [RadW-1:0]        rad1;

  logic signed [PdW-1:0]  pd2 [3];
  logic signed [PvW-1:0]  pv2 [3];
  logic [RrW-1:0]         rr2;

  logic signed [DotW-1:0] dot3;
  logic signed [LenW-1:0] len3;
  logic [RrW-1:0]         rr3;

  logic signed [DotW:0]   bround;
  logic signed [BW-1:0]   b4;
  logic signed [LrW-1:0]  lr4;

  logic signed [BW-1:0]   b5;
  logic signed [BbW-1:0]  bb5;
  logic signed [LrW-1:0]  lr5;

  logic signed [DiscW-1:0] disc;
  sq_data_t                head;

  assign cen[0] = center_x;
  assign cen[1] = center_y;
  assign cen[2] = center_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = $signed(s_tdata[i*PosW +: PosW]);
      dir[i] = $signed(s_tdata[3*PosW + i*DirW +: DirW]);
    end
  end

  // Each stage loads when it is empty or its successor loads this cycle.
  assign take6    = !out_valid || out_ready;
  assign take5    = !v5 || take6;
  assign take4    = !v4 || take5;
  assign take3    = !v3 || take4;
  assign take2    = !v2 || take3;
  assign take1    = !v1 || take2;
  assign s_tready = take1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take1) v1 <= s_tvalid;
      if (take2) v2 <= v1;
      if (take3) v3 <= v2;
      if (take4) v4 <= v3;
      if (take5) v5 <= v4;
      if (take6) out_valid <= v5;
    end
  end

  // Stage 1: offset from the center.
  always_ff @(posedge clk) begin
    if (take1) begin
      for (int i = 0; i < 3; i++) begin
        vec1[i] <= VecW'(org[i]) - VecW'(cen[i]);
        dir1[i] <= dir[i];
      end
      rad1 <= radius;
    end
  end

  // Stage 2: all products, each on its own multiplier.
  always_ff @(posedge clk) begin
    if (take2) begin
      for (int i = 0; i < 3; i++) begin
        pd2[i] <= PdW'(vec1[i]) * PdW'(dir1[i]);
        pv2[i] <= PvW'(vec1[i]) * PvW'(vec1[i]);
      end
      rr2 <= RrW'(rad1) * RrW'(rad1);
    end
  end

  // Stage 3: sums of the three terms.
  always_ff @(posedge clk) begin
    if (take3) begin
      dot3 <= DotW'(pd2[0]) + DotW'(pd2[1]) + DotW'(pd2[2]);
      len3 <= LenW'(pv2[0]) + LenW'(pv2[1]) + LenW'(pv2[2]);
      rr3  <= rr2;
    end
  end

  // Stage 4: b = -dot rounded to Q.12, half rounding up; the arithmetic
  // shift of the biased value is a floor.
  assign bround = (DotW+1)'(8192) - (DotW+1)'(dot3);

  always_ff @(posedge clk) begin
    if (take4) begin
      b4  <= bround[DotW:14];
      lr4 <= LrW'(len3) - LrW'($signed({1'b0, rr3}));
    end
  end

  // Stage 5: b squared.
  always_ff @(posedge clk) begin
    if (take5) begin
      b5  <= b4;
      bb5 <= BbW'(b4) * BbW'(b4);
      lr5 <= lr4;
    end
  end

  // Stage 6: discriminant; a miss enters the chain with a zero radicand.
  assign disc = DiscW'(bb5) - DiscW'(lr5);

  always_comb begin
    head.hit = (disc > 0);
    head.b   = b5;
    head.x   = head.hit ? disc[SqW-1:0] : '0;
    head.res = '0;
  end

  always_ff @(posedge clk) begin
    if (take6) begin
      out_data <= head;
    end
  end

endmodule

@@ hw/rtl/rsi_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// One step of the bit-by-bit integer square root, registered, with its own
// valid and a load enable that follows the downstream cell.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell #(
  parameter int K = 0   // this cell tests the root bit of weight 2**K
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rsi_pkg::sq_data_t in_data,
  output logic              out_valid,
  output rsi_pkg::sq_data_t out_data,
  input  logic              out_ready
);
  import rsi_pkg::*;

  localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * K);

  logic           take;
  logic [SqW-1:0] trial;
  sq_data_t       nxt;

  assign take     = !out_valid || out_ready;
  assign in_ready = take;
  assign trial    = in_data.res + Bit;

  always_comb begin
    nxt = in_data;
    if (in_data.x >= trial) begin
      nxt.x   = in_data.x - trial;
      nxt.res = (in_data.res >> 1) + Bit;
    end else begin
      nxt.res = in_data.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= nxt;
    end
  end

endmodule

@@ hw/rtl/ray_sphere_intersect_core.sv @@
// ----------------------------------------------------------------------------
// ray_sphere_intersect_core
// Ray against sphere test in fixed point: distances to both crossings.
//
//   Group  Dir  Signals                         Content
//   s_     in   tvalid tready tdata[119:0]      one ray
//   m_     out  tvalid tready tdata[63:0] tuser one result
//   cfg_   in   valid ready index data          sphere registers
//
// One ray enters per cycle while the output is not stalled; a result
// passes 6 front-end stages, 28 square root cells and one output register.
// Every stage holds its own valid, so a stall at the output fills the
// bubbles before it reaches the input.
// Reset empties the pipeline, puts the center at the origin and the
// radius at 1.0. cfg_ready is tied high, so writes are always accepted.
// ----------------------------------------------------------------------------
module ray_sphere_intersect_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // origin_x, origin_y, origin_z (24 each), dir_x, dir_y, dir_z (16 each)
  input  logic [rsi_pkg::InW-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // t_near [31:0], t_far [63:32]
  output logic [rsi_pkg::OutW-1:0]  m_tdata,
  // hit
  output logic                      m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rsi_pkg::IdxW-1:0]  cfg_index,
  input  logic [rsi_pkg::PosW-1:0]  cfg_data
);
  import rsi_pkg::*;

  logic signed [PosW-1:0] center_x;
  logic signed [PosW-1:0] center_y;
  logic signed [PosW-1:0] center_z;
  logic [RadW-1:0]        radius;

  logic     c_valid [NumCells+1];
  logic     c_ready [NumCells+1];
  sq_data_t c_data  [NumCells+1];

  sq_data_t             last;
  logic signed [TW:0]   bx;
  logic signed [TW:0]   rx;
  logic signed [TW:0]   t_near;
  logic signed [TW:0]   t_far;
  logic                 take_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      radius   <= RadiusReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegCenterX: center_x <= cfg_data;
        RegCenterY: center_y <= cfg_data;
        RegCenterZ: center_z <= cfg_data;
        RegRadius:  radius   <= cfg_data[RadW-1:0];
        default:    ;
      endcase
    end
  end

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .center_x  (center_x),
    .center_y  (center_y),
    .center_z  (center_z),
    .radius    (radius),
    .out_valid (c_valid[0]),
    .out_data  (c_data[0]),
    .out_ready (c_ready[0])
  );

  // The first cell tests the most significant root bit.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rsi_sqrt_cell #(
      .K (NumCells - 1 - i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_data   (c_data[i]),
      .out_valid (c_valid[i+1]),
      .out_data  (c_data[i+1]),
      .out_ready (c_ready[i+1])
    );
  end

  assign take_out          = !m_tvalid || m_tready;
  assign c_ready[NumCells] = take_out;
  assign last              = c_data[NumCells];
  assign bx                = (TW+1)'(last.b);
  assign rx                = $signed({{(TW+1-RootW){1'b0}}, last.res[RootW-1:0]});
  assign t_near            = bx - rx;
  assign t_far             = bx + rx;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take_out) begin
      m_tvalid <= c_valid[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      m_tuser <= last.hit;
      m_tdata <= last.hit ? {sat32(t_far), sat32(t_near)} : '0;
    end
  end

`ifndef SYNTH
  a_reset_empties: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("miss carries nonzero distances");

  a_hit_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> $signed(m_tdata[TW-1:0]) <= $signed(m_tdata[OutW-1:TW]))
    else $error("t_near beyond t_far");

  a_input_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled while the output is free");
`endif

endmodule
